FILE: design/lgs_pkg.sv
`default_nettype none

package lgs_pkg;

   // Light inputs are fixed 16-bit fields; the gamma index spans their full range.
   localparam int LIGHT_W    = 16;
   localparam int LIGHT_SPAN = 65536;

   // How the combined color is brought into 0..1.
   typedef enum logic [1:0] {
      MODE_KEEP  = 2'd0,
      MODE_ONE   = 2'd1,
      MODE_ZERO  = 2'd2,
      MODE_SCALE = 2'd3
   } lgs_mode_type;

   // Largest Y with Y^7 <= (3u)^5 * 2^(2*frac), i.e. floor((3u/one)^(5/7) * one).
   // Elaboration-time only.
   function automatic logic [31:0] gamma_root(input longint unsigned u, input int frac);
      logic [255:0] target;
      logic [255:0] trial;
      logic [31:0]  lo;
      logic [31:0]  hi;
      logic [31:0]  mid;
      target = 256'd1;
      for (int k = 0; k < 5; k++) begin
         target = target * (256'(u) * 256'd3);
      end
      target = target << (2 * frac);
      lo = 32'd0;
      hi = (32'd1 << (frac + 4)) + 32'd1;
      while ((hi - lo) > 32'd1) begin
         mid   = lo + ((hi - lo) >> 1);
         trial = 256'd1;
         for (int k = 0; k < 7; k++) begin
            trial = trial * 256'(mid);
         end
         if (trial <= target) begin
            lo = mid;
         end else begin
            hi = mid;
         end
      end
      return lo;
   endfunction

endpackage

`default_nettype wire

FILE: design/lgs_ram.sv
`default_nettype none

module lgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/lgs_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Caller guarantees num < den * 2^QUO_W. Side data rides along unchanged.
module lgs_div #(
   parameter int NUM_W  = 31,
   parameter int DEN_W  = 18,
   parameter int QUO_W  = 13,
   parameter int SIDE_W = 8
) (
   input  wire logic              clock,
   input  wire logic [QUO_W-1:0]  en,
   input  wire logic [NUM_W-1:0]  num,
   input  wire logic [DEN_W-1:0]  den,
   input  wire logic [SIDE_W-1:0] side,
   output logic      [QUO_W-1:0]  quo,
   output logic                   rem_nz,
   output logic      [SIDE_W-1:0] side_out
);

   logic [NUM_W-1:0]  rem_ff  [QUO_W];
   logic [DEN_W-1:0]  den_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];
   logic [NUM_W-1:0]  rem_in  [QUO_W];
   logic [QUO_W-1:0]  quo_in  [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      localparam int Bit = QUO_W - 1 - j;
      logic [NUM_W-1:0]  rem_src;
      logic [DEN_W-1:0]  den_src;
      logic [QUO_W-1:0]  quo_src;
      logic [SIDE_W-1:0] side_src;
      logic [NUM_W:0]    trial;

      if (j == 0) begin : g_first
         assign rem_src  = num;
         assign den_src  = den;
         assign quo_src  = '0;
         assign side_src = side;
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign den_src  = den_ff[j-1];
         assign quo_src  = quo_ff[j-1];
         assign side_src = side_ff[j-1];
      end

      assign trial = {1'b0, rem_src} - ((NUM_W + 1)'(den_src) << Bit);

      always_comb begin
         rem_in[j] = trial[NUM_W] ? rem_src : trial[NUM_W-1:0];
         quo_in[j] = trial[NUM_W] ? quo_src : (quo_src | (QUO_W'(1) << Bit));
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            rem_ff[j]  <= rem_in[j];
            den_ff[j]  <= den_src;
            quo_ff[j]  <= quo_in[j];
            side_ff[j] <= side_src;
         end
      end
   end

   assign quo      = quo_ff[QUO_W-1];
   assign rem_nz   = (rem_ff[QUO_W-1] != '0);
   assign side_out = side_ff[QUO_W-1];

endmodule

`default_nettype wire

FILE: design/lightmap_gamut_split.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  light_red/green/blue, texture_average
// rsp      out        rsp_valid / rsp_ready  mul_*, add_*, add_needed
//
// One request per cycle sustained while rsp_ready is high; rsp_valid rises once the request
// has passed the FRAC_BITS + 7 register stages (gamma RAM read, four arithmetic
// stages, FRAC_BITS+1 divider stages, output register). Most of the depth is the divider.
// After reset the three gamma RAMs are filled from the constant table, one entry
// per cycle, with req_ready low until the fill is done.
// Each stage holds only while it is full and everything after it is full and
// rsp is stalled, so bubbles close up and a request is accepted while a result waits.
`default_nettype none

module lightmap_gamut_split #(
   parameter int FRAC_BITS           = 12,
   parameter int GAMMA_TABLE_ENTRIES = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [lgs_pkg::LIGHT_W-1:0]       req_light_red,
   input  wire logic [lgs_pkg::LIGHT_W-1:0]       req_light_green,
   input  wire logic [lgs_pkg::LIGHT_W-1:0]       req_light_blue,
   input  wire logic [FRAC_BITS:0]                req_texture_average,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic        [FRAC_BITS:0]              rsp_mul_red,
   output logic        [FRAC_BITS:0]              rsp_mul_green,
   output logic        [FRAC_BITS:0]              rsp_mul_blue,
   output logic signed [FRAC_BITS+1:0]            rsp_add_red,
   output logic signed [FRAC_BITS+1:0]            rsp_add_green,
   output logic signed [FRAC_BITS+1:0]            rsp_add_blue,
   output logic                                   rsp_add_needed
);

   import lgs_pkg::*;

   localparam int F      = FRAC_BITS;
   localparam int ONE    = 1 << F;
   localparam int MW     = F + 1;          // mul, prod, texture
   localparam int AW     = F + 2;          // add output
   localparam int GW     = F + 5;          // gamma value
   localparam int CW     = F + 6;          // combined color, luminance
   localparam int QW     = F + 1;          // quotient bits
   localparam int NW     = CW + QW;        // divider numerator
   localparam int LW     = F + CW + 2;     // luminance sum
   localparam int XW     = CW + 3;         // signed output math
   localparam int IDX_W  = $clog2(GAMMA_TABLE_ENTRIES);
   localparam int CNT_W  = $clog2(GAMMA_TABLE_ENTRIES + 1);
   localparam int PW     = LIGHT_W + CNT_W;
   localparam int NST    = QW + 6;
   localparam int S_DIV  = 5;
   localparam int WR     = (299 * ONE + 500) / 1000;
   localparam int WG     = (587 * ONE + 500) / 1000;
   localparam int WB     = ONE - WR - WG;

   localparam logic signed [XW-1:0] ADD_HI = XW'(ONE);
   localparam logic signed [XW-1:0] ADD_LO = XW'(-2 * ONE);

   typedef struct packed {
      logic [CW-1:0] base;
      logic [MW-1:0] prod;
      logic [MW-1:0] mul;
      logic          neg;
   } lane_side_type;

   localparam int SW = $bits(lane_side_type);

   // ---------------- gamma table and RAM fill ----------------
   logic [GW-1:0] gamma_const [GAMMA_TABLE_ENTRIES];

   for (genvar gi = 0; gi < GAMMA_TABLE_ENTRIES; gi++) begin : g_rom
      localparam longint unsigned EntryBase =
         (longint'(gi) * longint'(LIGHT_SPAN)) / GAMMA_TABLE_ENTRIES;
      assign gamma_const[gi] = GW'(gamma_root(EntryBase, F));
   end

   logic [CNT_W-1:0] fill_cnt_ff;
   logic [CNT_W-1:0] fill_cnt_in;
   logic             fill_done;
   logic [IDX_W-1:0] fill_addr;

   assign fill_done   = (fill_cnt_ff == CNT_W'(GAMMA_TABLE_ENTRIES));
   assign fill_addr   = fill_cnt_ff[IDX_W-1:0];
   assign fill_cnt_in = fill_done ? fill_cnt_ff : fill_cnt_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_cnt_ff <= '0;
      end else begin
         fill_cnt_ff <= fill_cnt_in;
      end
   end

   // ---------------- stage valids and enables ----------------
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic [NST-1:0] en;
   logic           accept;

   // A stage may load when any stage from it to the output is empty, or rsp drains.
   always_comb begin
      for (int k = 0; k < NST; k++) begin
         en[k] = rsp_ready || (((~vld_ff) >> k) != '0);
      end
   end

   assign req_ready = fill_done && en[0];
   assign accept    = req_valid && req_ready;

   always_comb begin
      vld_in[0] = en[0] ? accept : vld_ff[0];
      for (int k = 1; k < NST; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- stage 1: gamma lookup ----------------
   logic [IDX_W-1:0] idx_in [3];
   logic [GW-1:0]    g1     [3];
   logic [MW-1:0]    tex1_ff;

   always_comb begin
      idx_in[0] = IDX_W'((PW'(req_light_red)   * PW'(GAMMA_TABLE_ENTRIES)) >> LIGHT_W);
      idx_in[1] = IDX_W'((PW'(req_light_green) * PW'(GAMMA_TABLE_ENTRIES)) >> LIGHT_W);
      idx_in[2] = IDX_W'((PW'(req_light_blue)  * PW'(GAMMA_TABLE_ENTRIES)) >> LIGHT_W);
   end

   for (genvar c = 0; c < 3; c++) begin : g_ram
      lgs_ram #(
         .WIDTH (GW),
         .DEPTH (GAMMA_TABLE_ENTRIES)
      ) u_ram (
         .clock   (clock),
         .wr_en   (!fill_done),
         .wr_addr (fill_addr),
         .wr_data (gamma_const[fill_addr]),
         .rd_en   (en[0]),
         .rd_addr (idx_in[c]),
         .rd_data (g1[c])
      );
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         tex1_ff <= req_texture_average;
      end
   end

   // ---------------- stage 2: clamp and split ----------------
   logic [MW-1:0] mul2_ff  [3];
   logic [MW-1:0] prod2_ff [3];
   logic [CW-1:0] addp2_ff [3];
   logic          need2_ff;
   logic [MW-1:0] mul2_in  [3];
   logic [MW-1:0] prod2_in [3];
   logic [CW-1:0] addp2_in [3];
   logic          need2_in;
   logic [2:0]    over2;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         over2[c]    = (g1[c] > GW'(ONE));
         mul2_in[c]  = over2[c] ? MW'(ONE) : g1[c][MW-1:0];
         addp2_in[c] = over2[c] ?
            CW'(((MW + GW)'(tex1_ff) * (MW + GW)'(g1[c] - GW'(ONE))) >> F) : '0;
         prod2_in[c] = MW'(((2 * MW)'(tex1_ff) * (2 * MW)'(mul2_in[c])) >> F);
      end
      need2_in = (over2 != '0);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         mul2_ff  <= mul2_in;
         prod2_ff <= prod2_in;
         addp2_ff <= addp2_in;
         need2_ff <= need2_in;
      end
   end

   // ---------------- stage 3: combined color ----------------
   logic [CW-1:0] comb3_ff [3];
   logic [MW-1:0] mul3_ff  [3];
   logic [MW-1:0] prod3_ff [3];
   logic          need3_ff;
   logic [CW-1:0] comb3_in [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         comb3_in[c] = CW'(prod2_ff[c]) + addp2_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         comb3_ff <= comb3_in;
         mul3_ff  <= mul2_ff;
         prod3_ff <= prod2_ff;
         need3_ff <= need2_ff;
      end
   end

   // ---------------- stage 4: luminance and peak ----------------
   logic [CW-1:0] lum4_ff;
   logic [CW-1:0] top4_ff;
   logic [CW-1:0] comb4_ff [3];
   logic [MW-1:0] mul4_ff  [3];
   logic [MW-1:0] prod4_ff [3];
   logic          need4_ff;
   logic [LW-1:0] lum_sum;
   logic [CW-1:0] lum4_in;
   logic [CW-1:0] top4_in;

   always_comb begin
      lum_sum = LW'(WR) * LW'(comb3_ff[0]) + LW'(WG) * LW'(comb3_ff[1])
              + LW'(WB) * LW'(comb3_ff[2]);
      lum4_in = CW'(lum_sum >> F);
      top4_in = (comb3_ff[1] > comb3_ff[0]) ? comb3_ff[1] : comb3_ff[0];
      if (comb3_ff[2] > top4_in) begin
         top4_in = comb3_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         lum4_ff  <= lum4_in;
         top4_ff  <= top4_in;
         comb4_ff <= comb3_ff;
         mul4_ff  <= mul3_ff;
         prod4_ff <= prod3_ff;
         need4_ff <= need3_ff;
      end
   end

   // ---------------- stage 5: gamut mode and divider operands ----------------
   // Scale case: c' = l + floor((c - l)(one - l) / (top - l)); other cases force
   // a zero quotient so c' = base.
   lgs_mode_type  mode5;
   logic [NW-1:0] num5_ff  [3];
   logic [CW-1:0] den5_ff;
   lane_side_type side5_ff [3];
   logic          need5_ff;
   logic [NW-1:0] num5_in  [3];
   logic [CW-1:0] den5_in;
   lane_side_type side5_in [3];
   logic [CW-1:0] mag5     [3];
   logic [QW-1:0] oml5;

   always_comb begin
      if (lum4_ff >= CW'(ONE)) begin
         mode5 = MODE_ONE;
      end else if (lum4_ff == '0) begin
         mode5 = MODE_ZERO;
      end else if (top4_ff > CW'(ONE)) begin
         mode5 = MODE_SCALE;
      end else begin
         mode5 = MODE_KEEP;
      end
      oml5    = QW'(ONE) - lum4_ff[QW-1:0];
      den5_in = (mode5 == MODE_SCALE) ? (top4_ff - lum4_ff) : CW'(1);
      for (int c = 0; c < 3; c++) begin
         side5_in[c].prod = prod4_ff[c];
         side5_in[c].mul  = mul4_ff[c];
         side5_in[c].neg  = (mode5 == MODE_SCALE) && (comb4_ff[c] < lum4_ff);
         mag5[c]          = (comb4_ff[c] < lum4_ff) ? (lum4_ff - comb4_ff[c])
                                                    : (comb4_ff[c] - lum4_ff);
         num5_in[c]       = (mode5 == MODE_SCALE) ? (NW'(mag5[c]) * NW'(oml5)) : '0;
         case (mode5)
            MODE_ONE:   side5_in[c].base = CW'(ONE);
            MODE_ZERO:  side5_in[c].base = '0;
            MODE_SCALE: side5_in[c].base = lum4_ff;
            default:    side5_in[c].base = comb4_ff[c];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         num5_ff  <= num5_in;
         den5_ff  <= den5_in;
         side5_ff <= side5_in;
         need5_ff <= need4_ff;
      end
   end

   // ---------------- divider stages ----------------
   logic [QW-1:0] quo_d   [3];
   logic          rnz_d   [3];
   lane_side_type side_d  [3];
   logic          need_d;

   lgs_div #(
      .NUM_W  (NW),
      .DEN_W  (CW),
      .QUO_W  (QW),
      .SIDE_W (SW + 1)
   ) u_div_red (
      .clock    (clock),
      .en       (en[S_DIV +: QW]),
      .num      (num5_ff[0]),
      .den      (den5_ff),
      .side     ({need5_ff, side5_ff[0]}),
      .quo      (quo_d[0]),
      .rem_nz   (rnz_d[0]),
      .side_out ({need_d, side_d[0]})
   );

   lgs_div #(
      .NUM_W  (NW),
      .DEN_W  (CW),
      .QUO_W  (QW),
      .SIDE_W (SW)
   ) u_div_green (
      .clock    (clock),
      .en       (en[S_DIV +: QW]),
      .num      (num5_ff[1]),
      .den      (den5_ff),
      .side     (side5_ff[1]),
      .quo      (quo_d[1]),
      .rem_nz   (rnz_d[1]),
      .side_out (side_d[1])
   );

   lgs_div #(
      .NUM_W  (NW),
      .DEN_W  (CW),
      .QUO_W  (QW),
      .SIDE_W (SW)
   ) u_div_blue (
      .clock    (clock),
      .en       (en[S_DIV +: QW]),
      .num      (num5_ff[2]),
      .den      (den5_ff),
      .side     (side5_ff[2]),
      .quo      (quo_d[2]),
      .rem_nz   (rnz_d[2]),
      .side_out (side_d[2])
   );

   // ---------------- output stage: add map with saturation ----------------
   logic [MW-1:0]          rsp_mul_ff [3];
   logic [AW-1:0]          rsp_add_ff [3];
   logic                   rsp_need_ff;
   logic [AW-1:0]          rsp_add_in [3];
   logic [XW-1:0]          qmag       [3];
   logic signed [XW-1:0]   delta      [3];
   logic signed [XW-1:0]   addv       [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         // floor of a negative quotient rounds away from zero
         qmag[c]  = XW'(quo_d[c]) + XW'(rnz_d[c]);
         delta[c] = side_d[c].neg ? -$signed(qmag[c]) : $signed(XW'(quo_d[c]));
         addv[c]  = $signed(XW'(side_d[c].base)) + delta[c]
                  - $signed(XW'(side_d[c].prod));
         if (!need_d) begin
            rsp_add_in[c] = '0;
         end else if (addv[c] > ADD_HI) begin
            rsp_add_in[c] = AW'(ADD_HI);
         end else if (addv[c] < ADD_LO) begin
            rsp_add_in[c] = AW'(ADD_LO);
         end else begin
            rsp_add_in[c] = AW'(addv[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[NST-1]) begin
         for (int c = 0; c < 3; c++) begin
            rsp_mul_ff[c] <= side_d[c].mul;
            rsp_add_ff[c] <= rsp_add_in[c];
         end
         rsp_need_ff <= need_d;
      end
   end

   assign rsp_valid      = vld_ff[NST-1];
   assign rsp_mul_red    = rsp_mul_ff[0];
   assign rsp_mul_green  = rsp_mul_ff[1];
   assign rsp_mul_blue   = rsp_mul_ff[2];
   assign rsp_add_red    = $signed(rsp_add_ff[0]);
   assign rsp_add_green  = $signed(rsp_add_ff[1]);
   assign rsp_add_blue   = $signed(rsp_add_ff[2]);
   assign rsp_add_needed = rsp_need_ff;

   // ---------------- checks ----------------
   a_no_req_during_fill: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> fill_done)
      else $error("request taken before gamma RAM fill finished");

   a_fill_stays_done: assert property (@(posedge clock) disable iff (reset)
      fill_done |=> fill_done)
      else $error("gamma RAM fill restarted");

   a_no_add_without_excess: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_add_needed) |->
         (rsp_add_red == '0 && rsp_add_green == '0 && rsp_add_blue == '0))
      else $error("add map nonzero without excess");

   a_mul_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mul_red <= MW'(ONE) && rsp_mul_green <= MW'(ONE)
                     && rsp_mul_blue <= MW'(ONE)))
      else $error("multiply map above one");

endmodule

`default_nettype wire
